// ===== hw/rtl/grw_pkg.sv =====
// Package for the growable replay window: sizes, request codes, item and row types, helpers.
package grw_pkg;

  localparam int BlockSize = 64;
  localparam int MaxBlocks = 16;
  localparam int TimeBits  = 48;

  localparam int BitW  = $clog2(BlockSize);
  localparam int RowW  = $clog2(MaxBlocks);
  localparam int ActW  = RowW + 1;
  localparam int CntW  = $clog2(BlockSize + 1);
  localparam int AddrW = RowW + 1;        // bank bit + row
  localparam int MsgW  = 64;
  localparam int NumW  = MsgW - BitW;     // block-granular distances

  typedef enum logic [1:0] {
    REQ_QUERY = 2'd0,
    REQ_LOG   = 2'd1,
    REQ_CLEAR = 2'd2,
    REQ_NOP   = 2'd3
  } req_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_OFF,
    S_CHK,
    S_LOC,
    S_RD,
    S_PLAN,
    S_SCAN_RD,
    S_SCAN_EV,
    S_DECIDE,
    S_GROW,
    S_CP_RD,
    S_CP_WR,
    S_FLIP,
    S_ADV
  } state_e;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [63:0] msg_number;
    logic [47:0] now_ms;
    logic [31:0] round_trip_ms;
  } grw_in_t;

  typedef struct packed {
    logic        seen;
    logic [63:0] window_low;
    logic [4:0]  window_blocks;
  } grw_out_t;

  typedef struct packed {
    logic [BlockSize-1:0] bits;
    logic [CntW-1:0]      count;
    logic [TimeBits-1:0]  stamp;
  } row_t;

  // Physical row of ring position k (first and k below active).
  function automatic logic [RowW-1:0] ring_row(input logic [RowW-1:0] first,
                                               input logic [ActW-1:0] k,
                                               input logic [ActW-1:0] active);
    logic [ActW:0] s;
    s = (ActW+1)'(first) + (ActW+1)'(k);
    if (s >= (ActW+1)'(active)) begin
      s = s - (ActW+1)'(active);
    end
    return s[RowW-1:0];
  endfunction

endpackage

// ===== hw/rtl/grw_row_mem.sv =====
// Block row memory: two banks of rows, one write and one registered read per cycle.
module grw_row_mem (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [grw_pkg::AddrW-1:0]  waddr_i,
  input  grw_pkg::row_t              wdata_i,
  input  logic [grw_pkg::AddrW-1:0]  raddr_i,
  output grw_pkg::row_t              rdata_o
);

  grw_pkg::row_t mem [2*grw_pkg::MaxBlocks];
  grw_pkg::row_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/growable_replay_window.sv =====
// Top level of the growable replay window: request sequencer around the block row memory.
// Paths per item: a query or log inside the window reads its row (a log writes it back);
// the window bounds decide alone (below base, query above); clear and no-op finish in S_OFF.
// A sliding log advances the ring when all 16 blocks are active; else it advances or grows
// after scanning up to 15 old blocks, and on growth copies each kept block to the other bank.
// One item at a time: busy stays high from accept to result; one row-memory port sets the pace.
// Reset (async, active low) clears all row valid bits, base, first block; one block is active.
// Results show for one cycle on result_valid_o; the receiver cannot stall.
module growable_replay_window (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  grw_pkg::grw_in_t   req_i,
  output logic               result_valid_o,
  output grw_pkg::grw_out_t  result_o
);

  localparam int VldW = 2 * grw_pkg::MaxBlocks;

  grw_pkg::state_e state_q, state_d;
  grw_pkg::grw_in_t req_q, req_d;

  // Window state. Rows live in one of two banks; bank_q picks the live one.
  logic [grw_pkg::MsgW-1:0] base_q, base_d;
  logic [grw_pkg::RowW-1:0] first_q, first_d;
  logic [grw_pkg::ActW-1:0] active_q, active_d;
  logic                     bank_q, bank_d;
  logic [VldW-1:0]          valid_q, valid_d;   // row not valid reads as all zero

  // Per-item working registers.
  logic [grw_pkg::MsgW-1:0] off_q, off_d;
  logic                     below_q, below_d;
  logic [grw_pkg::NumW-1:0] n_q, n_d;           // blocks to slide
  logic [grw_pkg::ActW-1:0] i_q, i_d;           // scan index / discard candidates
  logic [grw_pkg::ActW-1:0] lim_q, lim_d;
  logic [grw_pkg::ActW-1:0] extra_q, extra_d;   // growth in blocks
  logic [grw_pkg::ActW-1:0] dsc_q, dsc_d;       // discarded blocks when compacting
  logic [grw_pkg::ActW-1:0] keep_q, keep_d;
  logic [grw_pkg::ActW-1:0] j_q, j_d;           // copy index
  logic [grw_pkg::BitW-1:0] bit_q, bit_d;

  grw_pkg::grw_out_t res_q, res_d;
  logic              res_vld_q, res_vld_d;

  // Row memory port.
  logic                     we;
  logic [grw_pkg::AddrW-1:0] waddr, raddr, raddr_q;
  grw_pkg::row_t            wdata, rdata, row_rd;

  grw_row_mem u_mem (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Invalid rows read as zero (cleared or never written since last clear).
  assign row_rd = valid_q[raddr_q] ? rdata : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= grw_pkg::S_IDLE;
      base_q    <= '0;
      first_q   <= '0;
      active_q  <= grw_pkg::ActW'(1);
      bank_q    <= 1'b0;
      valid_q   <= '0;
      res_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      base_q    <= base_d;
      first_q   <= first_d;
      active_q  <= active_d;
      bank_q    <= bank_d;
      valid_q   <= valid_d;
      res_vld_q <= res_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q   <= req_d;
    off_q   <= off_d;
    below_q <= below_d;
    n_q     <= n_d;
    i_q     <= i_d;
    lim_q   <= lim_d;
    extra_q <= extra_d;
    dsc_q   <= dsc_d;
    keep_q  <= keep_d;
    j_q     <= j_d;
    bit_q   <= bit_d;
    res_q   <= res_d;
    raddr_q <= raddr;
  end

  always_comb begin
    logic                       finish;
    logic                       seen_v;
    logic                       in_win;
    logic [grw_pkg::TimeBits-1:0] age;
    logic [grw_pkg::NumW-1:0]   rem;
    logic [grw_pkg::NumW-1:0]   dd;
    logic [grw_pkg::ActW-1:0]   room;
    logic [grw_pkg::ActW-1:0]   lim_a;
    logic [grw_pkg::ActW-1:0]   nmod;
    logic [grw_pkg::ActW:0]     fsum;
    logic [grw_pkg::ActW:0]     lj;
    logic [grw_pkg::RowW-1:0]   row_i;
    grw_pkg::row_t              upd;

    state_d  = state_q;
    req_d    = req_q;
    base_d   = base_q;
    first_d  = first_q;
    active_d = active_q;
    bank_d   = bank_q;
    valid_d  = valid_q;
    off_d    = off_q;
    below_d  = below_q;
    n_d      = n_q;
    i_d      = i_q;
    lim_d    = lim_q;
    extra_d  = extra_q;
    dsc_d    = dsc_q;
    keep_d   = keep_q;
    j_d      = j_q;
    bit_d    = bit_q;
    res_d    = res_q;
    finish   = 1'b0;
    seen_v   = 1'b0;
    we       = 1'b0;
    waddr    = '0;
    wdata    = '0;
    raddr    = raddr_q;
    in_win   = off_q < grw_pkg::MsgW'({active_q, grw_pkg::BitW'(0)});
    age      = req_q.now_ms[grw_pkg::TimeBits-1:0] - row_rd.stamp;
    room     = grw_pkg::ActW'(grw_pkg::MaxBlocks) - active_q;
    rem      = n_q - grw_pkg::NumW'(i_q);
    dd       = n_q - grw_pkg::NumW'(extra_q);
    lim_a    = (n_q < grw_pkg::NumW'(active_q)) ? n_q[grw_pkg::ActW-1:0] : active_q;
    nmod     = '0;
    fsum     = '0;
    lj       = '0;
    row_i    = '0;
    upd      = row_rd;

    unique case (state_q)
      grw_pkg::S_IDLE: begin
        if (start) begin
          req_d   = req_i;
          state_d = grw_pkg::S_OFF;
        end
      end

      grw_pkg::S_OFF: begin
        off_d   = req_q.msg_number - base_q;
        below_d = req_q.msg_number < base_q;
        unique case (grw_pkg::req_e'(req_q.req_type))
          grw_pkg::REQ_CLEAR: begin
            valid_d = '0;
            first_d = '0;
            base_d  = '0;
            finish  = 1'b1;
          end
          grw_pkg::REQ_NOP: finish = 1'b1;
          default:          state_d = grw_pkg::S_CHK;
        endcase
      end

      grw_pkg::S_CHK: begin
        if (below_q) begin
          seen_v = (grw_pkg::req_e'(req_q.req_type) == grw_pkg::REQ_QUERY);
          finish = 1'b1;
        end else if (in_win) begin
          state_d = grw_pkg::S_LOC;
        end else if (grw_pkg::req_e'(req_q.req_type) == grw_pkg::REQ_QUERY) begin
          finish = 1'b1;
        end else begin
          // blocks to slide: floor((off - w) / BlockSize) + 1
          n_d = off_q[grw_pkg::MsgW-1:grw_pkg::BitW] - grw_pkg::NumW'(active_q)
              + grw_pkg::NumW'(1);
          state_d = grw_pkg::S_PLAN;
        end
      end

      grw_pkg::S_LOC: begin
        raddr = {bank_q, grw_pkg::ring_row(first_q,
                 grw_pkg::ActW'(off_q[grw_pkg::BitW+grw_pkg::RowW-1:grw_pkg::BitW]),
                 active_q)};
        bit_d   = off_q[grw_pkg::BitW-1:0];
        state_d = grw_pkg::S_RD;
      end

      grw_pkg::S_RD: begin
        if (grw_pkg::req_e'(req_q.req_type) == grw_pkg::REQ_QUERY) begin
          seen_v = row_rd.bits[bit_q];
        end else begin
          upd.bits[bit_q] = 1'b1;
          if (row_rd.count < grw_pkg::CntW'(grw_pkg::BlockSize)) begin
            upd.count = row_rd.count + grw_pkg::CntW'(1);
          end
          upd.stamp = req_q.now_ms[grw_pkg::TimeBits-1:0];
          we     = 1'b1;
          waddr  = raddr_q;
          wdata  = upd;
          valid_d[raddr_q] = 1'b1;
        end
        finish = 1'b1;
      end

      grw_pkg::S_PLAN: begin
        if (active_q == grw_pkg::ActW'(grw_pkg::MaxBlocks)) begin
          state_d = grw_pkg::S_ADV;
        end else begin
          lim_d   = lim_a;
          i_d     = '0;
          state_d = grw_pkg::S_SCAN_RD;
        end
      end

      grw_pkg::S_SCAN_RD: begin
        raddr   = {bank_q, grw_pkg::ring_row(first_q, i_q, active_q)};
        state_d = grw_pkg::S_SCAN_EV;
      end

      grw_pkg::S_SCAN_EV: begin
        // stop at the oldest block that is neither full nor stale
        if (row_rd.count < grw_pkg::CntW'(grw_pkg::BlockSize) &&
            age <= grw_pkg::TimeBits'(req_q.round_trip_ms)) begin
          state_d = grw_pkg::S_DECIDE;
        end else begin
          i_d = i_q + grw_pkg::ActW'(1);
          state_d = (i_q + grw_pkg::ActW'(1) == lim_q) ? grw_pkg::S_DECIDE
                                                     : grw_pkg::S_SCAN_RD;
        end
      end

      grw_pkg::S_DECIDE: begin
        extra_d = (rem < grw_pkg::NumW'(room)) ? rem[grw_pkg::ActW-1:0] : room;
        state_d = (extra_d == '0) ? grw_pkg::S_ADV : grw_pkg::S_GROW;
      end

      grw_pkg::S_GROW: begin
        base_d = base_q + {dd, grw_pkg::BitW'(0)};
        dsc_d  = dd[grw_pkg::ActW-1:0];
        keep_d = (dd > grw_pkg::NumW'(active_q)) ? '0 : active_q - dd[grw_pkg::ActW-1:0];
        j_d    = '0;
        for (int r = 0; r < grw_pkg::MaxBlocks; r++) begin
          valid_d[{~bank_q, grw_pkg::RowW'(r)}] = 1'b0;
        end
        state_d = (keep_d == '0) ? grw_pkg::S_FLIP : grw_pkg::S_CP_RD;
      end

      grw_pkg::S_CP_RD: begin
        raddr   = {bank_q, grw_pkg::ring_row(first_q, dsc_q + j_q, active_q)};
        state_d = grw_pkg::S_CP_WR;
      end

      grw_pkg::S_CP_WR: begin
        we    = 1'b1;
        waddr = {~bank_q, j_q[grw_pkg::RowW-1:0]};
        wdata = row_rd;
        valid_d[waddr] = 1'b1;
        j_d   = j_q + grw_pkg::ActW'(1);
        state_d = (j_d == keep_q) ? grw_pkg::S_FLIP : grw_pkg::S_CP_RD;
      end

      grw_pkg::S_FLIP: begin
        bank_d   = ~bank_q;
        active_d = active_q + extra_q;
        first_d  = '0;
        state_d  = grw_pkg::S_OFF;
      end

      grw_pkg::S_ADV: begin
        // zero the oldest min(n, active) ring blocks and rotate the ring
        for (int r = 0; r < grw_pkg::MaxBlocks; r++) begin
          row_i = grw_pkg::RowW'(r);
          lj = (row_i >= first_q)
             ? (grw_pkg::ActW+1)'(row_i) - (grw_pkg::ActW+1)'(first_q)
             : (grw_pkg::ActW+1)'(row_i) + (grw_pkg::ActW+1)'(active_q)
               - (grw_pkg::ActW+1)'(first_q);
          if (grw_pkg::ActW'(row_i) < active_q && lj < (grw_pkg::ActW+1)'(lim_a)) begin
            valid_d[{bank_q, row_i}] = 1'b0;
          end
        end
        // full ring: power-of-two mask; otherwise the slide never exceeds the ring
        if (active_q == grw_pkg::ActW'(grw_pkg::MaxBlocks)) begin
          nmod = grw_pkg::ActW'(n_q[grw_pkg::RowW-1:0]);
        end else if (n_q == grw_pkg::NumW'(active_q)) begin
          nmod = '0;
        end else begin
          nmod = n_q[grw_pkg::ActW-1:0];
        end
        fsum = (grw_pkg::ActW+1)'(first_q) + (grw_pkg::ActW+1)'(nmod);
        if (fsum >= (grw_pkg::ActW+1)'(active_q)) begin
          fsum = fsum - (grw_pkg::ActW+1)'(active_q);
        end
        first_d = fsum[grw_pkg::RowW-1:0];
        base_d  = base_q + {n_q, grw_pkg::BitW'(0)};
        state_d = grw_pkg::S_OFF;
      end

      default: state_d = grw_pkg::S_IDLE;
    endcase

    res_vld_d = finish;
    if (finish) begin
      state_d             = grw_pkg::S_IDLE;
      res_d.seen          = seen_v;
      res_d.window_low    = base_d;
      res_d.window_blocks = active_d;
    end
  end

  assign busy           = (state_q != grw_pkg::S_IDLE);
  assign result_valid_o = res_vld_q;
  assign result_o       = res_q;

endmodule

// ===== hw/rtl/grw_checker.sv =====
// Port-level checker for the growable replay window, bound to the top level.
module grw_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start,
  input logic              busy,
  input logic              result_valid_o,
  input grw_pkg::grw_out_t result_o
);

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("accepted item did not raise busy");

  a_result_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy)
    else $error("result shown while still busy");

  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("two results back to back");

  a_blocks_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (result_o.window_blocks != 5'd0 &&
                        result_o.window_blocks <= 5'(grw_pkg::MaxBlocks)))
    else $error("active block count out of range");

endmodule

bind growable_replay_window grw_checker u_grw_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .result_valid_o (result_valid_o),
  .result_o       (result_o)
);
